>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Check that holds at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/mlk_pkg.sv
// ----------------------------------------------------------------------------
// Morse letter keyer package
// Shared types, constants, the Morse table and the count saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mlk_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int REG_WIDTH   = 16;

  localparam logic [32:0] CNT_MAX = 33'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [7:0] LETTER_A = 8'h61;
  localparam logic [7:0] LETTER_Z = 8'h7A;

  typedef enum logic [1:0] {
    CFG_DOT  = 2'd0,
    CFG_DASH = 2'd1,
    CFG_GAP  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [REG_WIDTH-1:0] dot_ticks;
    logic [REG_WIDTH-1:0] dash_ticks;
    logic [REG_WIDTH-1:0] gap_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic [3:0] pat;
    logic [2:0] len;
  } morse_entry_t;

  typedef struct packed {
    logic led_on;
    logic busy_res;
    logic bad_letter;
    logic done_res;
  } result_t;

  // Bit i of the pattern is symbol i, 1 for a dash.
  function automatic morse_entry_t morse_lookup(input logic [4:0] idx);
    morse_entry_t e;
    case (idx)
      5'd0:    e = '{4'd2,  3'd2};
      5'd1:    e = '{4'd1,  3'd4};
      5'd2:    e = '{4'd5,  3'd4};
      5'd3:    e = '{4'd1,  3'd3};
      5'd4:    e = '{4'd0,  3'd1};
      5'd5:    e = '{4'd4,  3'd4};
      5'd6:    e = '{4'd3,  3'd3};
      5'd7:    e = '{4'd0,  3'd4};
      5'd8:    e = '{4'd0,  3'd2};
      5'd9:    e = '{4'd14, 3'd4};
      5'd10:   e = '{4'd5,  3'd3};
      5'd11:   e = '{4'd2,  3'd4};
      5'd12:   e = '{4'd3,  3'd2};
      5'd13:   e = '{4'd1,  3'd2};
      5'd14:   e = '{4'd7,  3'd3};
      5'd15:   e = '{4'd6,  3'd4};
      5'd16:   e = '{4'd11, 3'd4};
      5'd17:   e = '{4'd2,  3'd3};
      5'd18:   e = '{4'd0,  3'd3};
      5'd19:   e = '{4'd1,  3'd1};
      5'd20:   e = '{4'd4,  3'd3};
      5'd21:   e = '{4'd8,  3'd4};
      5'd22:   e = '{4'd6,  3'd3};
      5'd23:   e = '{4'd9,  3'd4};
      5'd24:   e = '{4'd13, 3'd4};
      5'd25:   e = '{4'd3,  3'd4};
      default: e = '{4'd0,  3'd0};
    endcase
    return e;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [REG_WIDTH-1:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > CNT_MAX) begin
      return '1;
    end
    return COUNT_WIDTH'(v);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mlk_intf.sv
// ----------------------------------------------------------------------------
// Morse letter keyer channels
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlk_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] letter;

  modport source (output valid, func, letter, input ready);
  modport sink   (input valid, func, letter, output ready);
endinterface

interface mlk_result_if;
  logic valid;
  logic ready;
  logic led_on;
  logic busy_res;
  logic bad_letter;
  logic done_res;

  modport source (output valid, led_on, busy_res, bad_letter, done_res, input ready);
  modport sink   (input valid, led_on, busy_res, bad_letter, done_res, output ready);
endinterface

interface mlk_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mlk_cfg_regs.sv
// ----------------------------------------------------------------------------
// Morse letter keyer configuration registers
// Holds the dot, dash and gap durations written over the register channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mlk_cfg_regs (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [1:0]            wr_index,
  input  wire logic [15:0]           wr_data,
  output      mlk_pkg::cfg_regs_t    regs
);
  import mlk_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dot_ticks  <= REG_WIDTH'(100);
      regs.dash_ticks <= REG_WIDTH'(1000);
      regs.gap_ticks  <= REG_WIDTH'(150);
    end else if (wr_en) begin
      case (wr_index)
        CFG_DOT:  regs.dot_ticks  <= wr_data;
        CFG_DASH: regs.dash_ticks <= wr_data;
        CFG_GAP:  regs.gap_ticks  <= wr_data;
        default:  ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mlk_core.sv
// ----------------------------------------------------------------------------
// Morse letter keyer core
// Keying state and the single-pass update for one start or tick word.
// ----------------------------------------------------------------------------
`default_nettype none

module mlk_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic               func,
  input  wire logic [7:0]         letter,
  input  wire mlk_pkg::cfg_regs_t regs,
  output      mlk_pkg::result_t   res
);
  import mlk_pkg::*;

  logic [3:0]             symbol_pattern, symbol_pattern_next;
  logic [2:0]             symbol_count, symbol_count_next;
  logic [2:0]             symbol_index, symbol_index_next;
  logic                   lit_phase, lit_phase_next;
  logic [COUNT_WIDTH-1:0] ticks_left, ticks_left_next;
  logic                   sending, sending_next;

  always_comb begin
    morse_entry_t e;
    logic [7:0]   ofs;
    logic [2:0]   idx_inc;
    symbol_pattern_next = symbol_pattern;
    symbol_count_next   = symbol_count;
    symbol_index_next   = symbol_index;
    lit_phase_next      = lit_phase;
    ticks_left_next     = ticks_left;
    sending_next        = sending;
    res.bad_letter      = 1'b0;
    res.done_res        = 1'b0;
    ofs                 = letter - LETTER_A;
    e                   = morse_lookup(ofs[4:0]);
    idx_inc             = symbol_index + 3'd1;
    if (func == FUNC_START) begin
      if (!sending) begin
        if (letter inside {[LETTER_A:LETTER_Z]}) begin
          symbol_pattern_next = e.pat;
          symbol_count_next   = e.len;
          symbol_index_next   = 3'd0;
          sending_next        = 1'b1;
          lit_phase_next      = 1'b1;
          ticks_left_next     = sat_count(e.pat[0] ? regs.dash_ticks : regs.dot_ticks);
        end else begin
          res.bad_letter = 1'b1;
        end
      end
    end else if (sending) begin
      if (ticks_left > COUNT_WIDTH'(1)) begin
        ticks_left_next = ticks_left - COUNT_WIDTH'(1);
      end else if (lit_phase) begin
        lit_phase_next  = 1'b0;
        ticks_left_next = sat_count(regs.gap_ticks);
      end else begin
        symbol_index_next = idx_inc;
        if (idx_inc >= symbol_count) begin
          sending_next    = 1'b0;
          ticks_left_next = '0;
          res.done_res    = 1'b1;
        end else begin
          lit_phase_next  = 1'b1;
          ticks_left_next = sat_count(symbol_pattern[idx_inc[1:0]] ?
                                      regs.dash_ticks : regs.dot_ticks);
        end
      end
    end
    res.led_on   = lit_phase_next & sending_next;
    res.busy_res = sending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_pattern <= '0;
      symbol_count   <= '0;
      symbol_index   <= '0;
      lit_phase      <= 1'b0;
      ticks_left     <= '0;
      sending        <= 1'b0;
    end else if (fire) begin
      symbol_pattern <= symbol_pattern_next;
      symbol_count   <= symbol_count_next;
      symbol_index   <= symbol_index_next;
      lit_phase      <= lit_phase_next;
      ticks_left     <= ticks_left_next;
      sending        <= sending_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mlk_out_reg.sv
// ----------------------------------------------------------------------------
// Morse letter keyer result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mlk_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire mlk_pkg::result_t res_in,
  output      logic             can_load,
  mlk_result_if.source          result
);
  import mlk_pkg::*;

  logic    full;
  result_t data;

  assign can_load = !full || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (result.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res_in;
    end
  end

  assign result.valid      = full;
  assign result.led_on     = data.led_on;
  assign result.busy_res   = data.busy_res;
  assign result.bad_letter = data.bad_letter;
  assign result.done_res   = data.done_res;

endmodule

`default_nettype wire

>>> hw/rtl/morse_letter_led_keyer.sv
// ----------------------------------------------------------------------------
// Morse letter keyer
// Keys the Morse code of a letter a to z on an LED, paced by tick words.
// ----------------------------------------------------------------------------
// The item channel takes one word per command: func 0 starts a letter, func 1
// is a one millisecond tick. Each accepted word yields exactly one result word
// carrying the LED level and the busy, bad letter and done flags, in order.
// The cfg channel writes the dot, dash and gap durations; it is always ready
// and is meant to be written while the keyer is idle.
// An accepted word is held in the input register, and the keying state is
// updated as it moves into the result register, where the result word stays
// valid until the receiver takes it. One word per cycle is sustained while the
// receiver takes each result, set by the single pass from input register to
// result register.
// Reset loads durations of 100, 1000 and 150 ticks, clears the keying state
// with the LED dark, and empties both registers.
// When the receiver stalls, the result register holds its word, the input
// register fills, and item.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_letter_led_keyer (
  input  wire logic    clk,
  input  wire logic    rst,
  mlk_item_if.sink     item,
  mlk_result_if.source result,
  mlk_cfg_if.sink      cfg
);
  import mlk_pkg::*;

  logic       in_full;
  logic       in_func;
  logic [7:0] in_letter;
  logic       can_load;
  logic       fire;
  cfg_regs_t  regs;
  result_t    res;

  assign fire       = in_full && can_load;
  assign item.ready = !in_full || can_load;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_func   <= item.func;
      in_letter <= item.letter;
    end
  end

  mlk_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (regs)
  );

  mlk_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .func   (in_func),
    .letter (in_letter),
    .regs   (regs),
    .res    (res)
  );

  mlk_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res_in   (res),
    .can_load (can_load),
    .result   (result)
  );

endmodule

`default_nettype wire

>>> hw/rtl/mlk_checker.sv
// ----------------------------------------------------------------------------
// Morse letter keyer checker
// Checks on the result channel of the keyer as seen at its ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mlk_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic led_on,
  input wire logic busy_res,
  input wire logic bad_letter,
  input wire logic done_res
);

  `ASSERT_ALWAYS(a_idle_after_reset, clk, $past(rst), !out_valid)
  `ASSERT_NEXT(a_valid_held, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_led_needs_busy, clk, rst, out_valid && led_on, busy_res)
  `ASSERT_IMPL(a_done_ends_letter, clk, rst, out_valid && done_res,
               !busy_res && !led_on && !bad_letter)

endmodule

bind morse_letter_led_keyer mlk_checker u_mlk_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .led_on     (result.led_on),
  .busy_res   (result.busy_res),
  .bad_letter (result.bad_letter),
  .done_res   (result.done_res)
);

`default_nettype wire
